### hdl/spct_pkg.sv
// Package for the sorted pair count table: widths, defaults, operation codes,
// controller commands and status. No dependencies.
package spct_pkg;
    localparam int unsigned DefEntries   = 1024;
    localparam int unsigned DefNodeBits  = 10;
    localparam int unsigned DefCountBits = 32;
    localparam int unsigned IdxBits      = 10;
    localparam int unsigned UsedBits     = 11;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input transfer
        logic scan_start; // reset scan pointer, issue first read
        logic scan_step;  // advance scan pointer, issue next read
        logic shift_start;// point shift at last entry, issue read
        logic shift_wait; // hold read of entry below shift pointer
        logic shift_step; // write entry k from k-1, step down
        logic write_hit;  // write incremented count at hit
        logic write_new;  // write new entry at insert point
        logic rd_issue;   // issue read for a read item
        logic rd_wait;    // hold read address for a read item
        logic res_hit;    // build results
        logic res_new;
        logic res_full;
        logic res_read;
    } spct_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic scan_end;   // pointer reached stored count
        logic cmp_ge;     // registered entry not below the pair
        logic cmp_eq;
        logic is_full;
        logic shift_done; // shift pointer reached insert point
        logic rd_valid;   // read index in range
    } spct_sts_t;
endpackage

### hdl/spct_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module spct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hdl/spct_ctrl.sv
// Controller state machine for the sorted pair count table.
// Depends on spct_pkg.
module spct_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    output logic                in_ready,
    output logic                res_valid,
    input  logic                res_ready,
    input  spct_pkg::spct_sts_t sts,
    output spct_pkg::spct_cmd_t cmd
);
    import spct_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DISP  = 9'b000000010,
        ST_SWAIT = 9'b000000100,
        ST_SCMP  = 9'b000001000,
        ST_SHWT  = 9'b000010000,
        ST_SHIFT = 9'b000100000,
        ST_RWAIT = 9'b001000000,
        ST_RDATA = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (sts.is_read) begin
                    cmd.rd_issue = 1'b1;
                    state_next = ST_RWAIT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                if (!sts.scan_end && sts.cmp_ge && sts.cmp_eq) begin
                    cmd.write_hit = 1'b1;
                    cmd.res_hit = 1'b1;
                    state_next = ST_OUT;
                end else if (sts.scan_end || sts.cmp_ge) begin
                    if (sts.is_full) begin
                        cmd.res_full = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        cmd.shift_start = 1'b1;
                        state_next = ST_SHWT;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                    state_next = ST_SWAIT;
                end
            end
            ST_SHWT: begin
                cmd.shift_wait = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (sts.shift_done) begin
                    cmd.write_new = 1'b1;
                    cmd.res_new = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.shift_step = 1'b1;
                    state_next = ST_SHWT;
                end
            end
            ST_RWAIT: begin
                cmd.rd_wait = 1'b1;
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                cmd.res_read = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    as_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    as_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> in_ready) else $error("load outside idle");
    as_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid) else $error("result dropped");
endmodule

### hdl/spct_dp.sv
// Datapath for the sorted pair count table: entry memories, pointers, result.
// Depends on spct_pkg and spct_ram.
module spct_dp #(
    parameter int unsigned ENTRIES    = spct_pkg::DefEntries,
    parameter int unsigned NODE_BITS  = spct_pkg::DefNodeBits,
    parameter int unsigned COUNT_BITS = spct_pkg::DefCountBits
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_op,
    input  logic [NODE_BITS-1:0]         in_from,
    input  logic [NODE_BITS-1:0]         in_to,
    input  logic [spct_pkg::IdxBits-1:0] in_idx,
    input  spct_pkg::spct_cmd_t          cmd,
    output spct_pkg::spct_sts_t          sts,
    output logic [NODE_BITS-1:0]         r_from,
    output logic [NODE_BITS-1:0]         r_to,
    output logic [COUNT_BITS-1:0]        r_count,
    output logic                         r_new,
    output logic                         r_full,
    output logic                         r_valid,
    output logic [spct_pkg::IdxBits-1:0] r_pos,
    output logic [spct_pkg::UsedBits-1:0] r_used
);
    import spct_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned RW = (CW > IdxBits) ? CW : IdxBits;
    localparam int unsigned EW = 2 * NODE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    logic                  op_reg;
    logic [NODE_BITS-1:0]  from_reg, to_reg;
    logic [IdxBits-1:0]    idx_reg;
    logic [CW-1:0]         used_reg, ptr_reg, ptr_next;
    logic [CW-1:0]         ins_reg;
    logic [AW-1:0]         addr;
    logic                  we;
    logic [EW-1:0]         wdata, rdata;
    logic [NODE_BITS-1:0]  rd_from, rd_to;
    logic [COUNT_BITS-1:0] rd_count, inc_count;
    logic                  rd_range;

    assign rd_from  = rdata[EW-1 -: NODE_BITS];
    assign rd_to    = rdata[COUNT_BITS +: NODE_BITS];
    assign rd_count = rdata[COUNT_BITS-1:0];
    assign inc_count = (rd_count == CountMax) ? rd_count : rd_count + 1'b1;
    assign rd_range = (RW'(idx_reg) < RW'(used_reg));

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.scan_start) ptr_next = '0;
        else if (cmd.scan_step) ptr_next = ptr_reg + 1'b1;
        else if (cmd.shift_start) ptr_next = used_reg;
        else if (cmd.shift_step) ptr_next = ptr_reg - 1'b1;
    end

    // memory address: read at scan/shift source, write at destination
    always_comb begin
        we = 1'b0;
        wdata = rdata;
        addr = ptr_next[AW-1:0];
        if (cmd.shift_start || cmd.shift_wait) begin
            addr = ptr_next[AW-1:0] - 1'b1;
        end
        if (cmd.rd_issue || cmd.rd_wait) begin
            addr = AW'(idx_reg);
        end
        if (cmd.shift_step) begin
            we = 1'b1;
            addr = ptr_reg[AW-1:0];
        end
        if (cmd.write_hit) begin
            we = 1'b1;
            addr = ptr_reg[AW-1:0];
            wdata = {rd_from, rd_to, inc_count};
        end
        if (cmd.write_new) begin
            we = 1'b1;
            addr = ins_reg[AW-1:0];
            wdata = {from_reg, to_reg, COUNT_BITS'(1)};
        end
    end

    spct_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign sts.is_read    = op_reg;
    assign sts.scan_end   = (ptr_reg == used_reg);
    assign sts.cmp_ge     = (rd_from > from_reg) || (rd_from == from_reg && rd_to >= to_reg);
    assign sts.cmp_eq     = (rd_from == from_reg) && (rd_to == to_reg);
    assign sts.is_full    = (used_reg == CW'(ENTRIES));
    assign sts.shift_done = (ptr_reg == ins_reg);
    assign sts.rd_valid   = rd_range;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op;
            from_reg <= in_from;
            to_reg <= in_to;
            idx_reg <= in_idx;
        end
        ptr_reg <= ptr_next;
        if (cmd.shift_start) ins_reg <= ptr_reg;
        if (cmd.res_hit) begin
            r_from <= rd_from; r_to <= rd_to; r_count <= inc_count;
            r_new <= 1'b0; r_full <= 1'b0; r_valid <= 1'b0;
            r_pos <= IdxBits'(ptr_reg);
            r_used <= UsedBits'(used_reg);
        end
        if (cmd.res_full) begin
            r_from <= from_reg; r_to <= to_reg; r_count <= '0;
            r_new <= 1'b0; r_full <= 1'b1; r_valid <= 1'b0;
            r_pos <= '0;
            r_used <= UsedBits'(used_reg);
        end
        if (cmd.res_new) begin
            r_from <= from_reg; r_to <= to_reg; r_count <= COUNT_BITS'(1);
            r_new <= 1'b1; r_full <= 1'b0; r_valid <= 1'b0;
            r_pos <= IdxBits'(ins_reg);
            r_used <= UsedBits'(used_reg + 1'b1);
        end
        if (cmd.res_read) begin
            r_from <= rd_range ? rd_from : '0;
            r_to <= rd_range ? rd_to : '0;
            r_count <= rd_range ? rd_count : '0;
            r_new <= 1'b0; r_full <= 1'b0; r_valid <= rd_range;
            r_pos <= idx_reg;
            r_used <= UsedBits'(used_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.write_new) begin
            used_reg <= used_reg + 1'b1;
        end
    end

    as_used_max: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(ENTRIES)) else $error("entry count overflow");
    as_new_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_new |-> !sts.is_full) else $error("insert into full table");
    as_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_step |-> ptr_reg > ins_reg) else $error("shift past insert point");
endmodule

### hdl/sorted_pair_count_table.sv
// Top level of the sorted pair count table: controller plus datapath.
// Depends on spct_pkg, spct_ctrl, spct_dp (and spct_ram beneath it).
//
//  Channel | Dir | tdata (low bit up)                  | tuser
//  s_      | in  | from_node, to_node, read_index       | operation
//  m_      | out | pair_from, pair_to, occurrences,     | was_new, table_full,
//          |     | position, entries_used              | index_valid
//
// A read issues one memory read and builds its result from the registered
// data. An add scans the stored entries in turn (single memory port, registered
// read), then an insert moves every entry from the insert point up by one
// through the same port.
// Reset clears the stored count only; entry memory needs no clearing.
// One item at a time: s_tready is high only when idle and the result has gone.
module sorted_pair_count_table #(
    parameter int unsigned ENTRIES    = spct_pkg::DefEntries,
    parameter int unsigned NODE_BITS  = spct_pkg::DefNodeBits,
    parameter int unsigned COUNT_BITS = spct_pkg::DefCountBits
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // from_node[9:0], to_node[19:10], read_index[29:20]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pair_from[9:0], pair_to[19:10], occurrences[51:20],
                                   // position[61:52], entries_used[72:62]
    output logic [2:0]  m_tuser    // was_new, table_full, index_valid
);
    import spct_pkg::*;

    spct_cmd_t cmd;
    spct_sts_t sts;
    logic [NODE_BITS-1:0]  r_from, r_to;
    logic [COUNT_BITS-1:0] r_count;
    logic [IdxBits-1:0]    r_pos;
    logic [UsedBits-1:0]   r_used;
    logic                  r_new, r_full, r_valid;

    spct_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .in_ready(s_tready),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    spct_dp #(.ENTRIES(ENTRIES), .NODE_BITS(NODE_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_op(s_tuser),
        .in_from(NODE_BITS'(s_tdata[9:0])),
        .in_to(NODE_BITS'(s_tdata[19:10])),
        .in_idx(s_tdata[29:20]),
        .cmd(cmd), .sts(sts),
        .r_from(r_from), .r_to(r_to), .r_count(r_count),
        .r_new(r_new), .r_full(r_full), .r_valid(r_valid),
        .r_pos(r_pos), .r_used(r_used)
    );

    // fields packed from bit 0 up, zero pad to whole bytes
    assign m_tdata  = {7'b0, r_used, r_pos, 32'(r_count), 10'(r_to), 10'(r_from)};
    assign m_tuser  = {r_valid, r_full, r_new};
endmodule
